/* hdl/salc_pkg.sv */
package salc_pkg;

   localparam int ADDR_W       = 64;
   localparam int TAG_W        = 64;
   localparam int COUNT_W      = 32;
   localparam int SET_BITS_W   = 3;
   localparam int WAYS_W       = 4;
   localparam int BLOCK_BITS_W = 6;
   localparam int CSR_DATA_W   = 6;
   localparam int CSR_INDEX_W  = 2;

   localparam int DEF_MAX_SET_BITS = 6;
   localparam int DEF_MAX_WAYS     = 8;
   localparam int DEF_STAMP_WIDTH  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_BITS = 2'd2;

   typedef enum logic [1:0] {
      OP_FETCH  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_STORE  = 2'd2,
      OP_MODIFY = 2'd3
   } salc_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOOKUP,
      ST_SCAN,
      ST_EVICT
   } salc_state_type;

   typedef struct packed {
      logic [SET_BITS_W-1:0]   set_bits;
      logic [WAYS_W-1:0]       ways_in_use;
      logic [BLOCK_BITS_W-1:0] block_bits;
   } salc_cfg_type;

   typedef struct packed {
      logic       done;
      logic [1:0] hits;
      logic       miss;
      logic       evict;
   } salc_event_type;

endpackage

/* hdl/salc_csr.sv */
module salc_csr #(
   parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [salc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]    csr_data,
   output salc_pkg::salc_cfg_type             cfg
);
   import salc_pkg::*;

   salc_cfg_type cfg_ff;
   salc_cfg_type cfg_in;
   logic [SET_BITS_W-1:0] set_v;
   logic [WAYS_W-1:0]     ways_v;

   always_comb begin
      cfg_in = cfg_ff;
      set_v  = csr_data[SET_BITS_W-1:0];
      ways_v = csr_data[WAYS_W-1:0];
      if (csr_write) begin
         case (csr_index)
            CSR_SET_BITS: begin
               if (32'(set_v) > MAX_SET_BITS) begin
                  cfg_in.set_bits = SET_BITS_W'(MAX_SET_BITS);
               end else begin
                  cfg_in.set_bits = set_v;
               end
            end
            CSR_WAYS: begin
               if (ways_v == '0) begin
                  cfg_in.ways_in_use = WAYS_W'(1);
               end else if (32'(ways_v) > MAX_WAYS) begin
                  cfg_in.ways_in_use = WAYS_W'(MAX_WAYS);
               end else begin
                  cfg_in.ways_in_use = ways_v;
               end
            end
            CSR_BLOCK_BITS: cfg_in.block_bits = csr_data[BLOCK_BITS_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_bits    <= '0;
         cfg_ff.ways_in_use <= WAYS_W'(1);
         cfg_ff.block_bits  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/salc_line_mem.sv */
module salc_line_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_B = 6,
   parameter int ROW_W  = 8
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_B-1:0] rd_addr,
   output logic [ROW_W-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_B-1:0] wr_addr,
   input  logic [ROW_W-1:0]  wr_data
);

   logic [ROW_W-1:0] mem [DEPTH];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/salc_ctrl.sv */
module salc_ctrl #(
   parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
   parameter int STAMP_WIDTH  = salc_pkg::DEF_STAMP_WIDTH,
   parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
   parameter int ROW_W        = MAX_WAYS * (1 + salc_pkg::TAG_W + STAMP_WIDTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  salc_pkg::salc_cfg_type        cfg,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_operation,
   input  logic [salc_pkg::ADDR_W-1:0]   req_address,
   output logic                          rd_en,
   output logic [SET_W-1:0]              rd_addr,
   input  logic [ROW_W-1:0]              rd_data,
   output logic                          wr_en,
   output logic [SET_W-1:0]              wr_addr,
   output logic [ROW_W-1:0]              wr_data,
   output salc_pkg::salc_event_type      ev
);
   import salc_pkg::*;

   localparam int NUM_SETS  = 1 << MAX_SET_BITS;
   localparam int LINE_W    = 1 + TAG_W + STAMP_WIDTH;
   localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
   localparam int CMP_W     = (WCNT_W > WAYS_W) ? WCNT_W : WAYS_W;

   salc_state_type state_ff, state_in;
   logic [SET_W-1:0]       clr_ff, clr_in;
   logic [SET_W-1:0]       set_ff, set_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic                   modify_ff, modify_in;
   logic [STAMP_WIDTH-1:0] time_ff, time_in;
   logic [WCNT_W-1:0]      scan_ff, scan_in;
   logic [WAY_W-1:0]       best_ff, best_in;
   logic [STAMP_WIDTH-1:0] best_stamp_ff, best_stamp_in;

   logic [MAX_WAYS-1:0]                   way_valid;
   logic [MAX_WAYS-1:0][TAG_W-1:0]        way_tag;
   logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0]  way_stamp;
   logic [MAX_WAYS-1:0]                   hit_vec;
   logic [MAX_WAYS-1:0]                   inv_vec;
   logic [WAY_W-1:0]                      hit_way;
   logic [WAY_W-1:0]                      inv_way;
   logic [WAY_W-1:0]                      sel_way;
   logic [ROW_W-1:0]                      new_row;
   logic [6:0]                            tag_sh;
   logic [ADDR_W-1:0]                     set_full;
   logic [ADDR_W-1:0]                     set_mask;
   logic [STAMP_WIDTH-1:0]                scan_stamp;

   // unpack the row that was read and find hit and first free way
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         way_valid[w] = rd_data[w*LINE_W + LINE_W - 1];
         way_tag[w]   = rd_data[w*LINE_W + STAMP_WIDTH +: TAG_W];
         way_stamp[w] = rd_data[w*LINE_W +: STAMP_WIDTH];
         if (CMP_W'(w) < CMP_W'(cfg.ways_in_use)) begin
            hit_vec[w] = way_valid[w] && (way_tag[w] == tag_ff);
            inv_vec[w] = !way_valid[w];
         end else begin
            hit_vec[w] = 1'b0;
            inv_vec[w] = 1'b0;
         end
      end
      hit_way = '0;
      inv_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (inv_vec[w]) begin
            inv_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      set_in        = set_ff;
      tag_in        = tag_ff;
      modify_in     = modify_ff;
      time_in       = time_ff;
      scan_in       = scan_ff;
      best_in       = best_ff;
      best_stamp_in = best_stamp_ff;
      busy          = 1'b1;
      rd_en         = 1'b0;
      rd_addr       = set_ff;
      wr_en         = 1'b0;
      wr_addr       = set_ff;
      ev            = '0;

      tag_sh   = {1'b0, cfg.block_bits} + 7'(cfg.set_bits);
      set_mask = ~({ADDR_W{1'b1}} << cfg.set_bits);
      set_full = (req_address >> cfg.block_bits) & set_mask;
      scan_stamp = way_stamp[scan_ff[WAY_W-1:0]];

      if (hit_vec != '0) begin
         sel_way = hit_way;
      end else if (state_ff == ST_LOOKUP) begin
         sel_way = inv_way;
      end else begin
         sel_way = best_ff;
      end
      new_row = rd_data;
      new_row[sel_way*LINE_W +: LINE_W] = {1'b1, tag_ff, time_ff};
      wr_data = new_row;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               set_in    = set_full[SET_W-1:0];
               tag_in    = tag_sh[6] ? '0 : (req_address >> tag_sh[5:0]);
               modify_in = (salc_op_type'(req_operation) == OP_MODIFY);
               if (time_ff != '1) begin
                  time_in = time_ff + 1'b1;
               end
               if (salc_op_type'(req_operation) == OP_FETCH) begin
                  ev.done = 1'b1;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            // a modify's second access always hits the line just touched
            if (hit_vec != '0) begin
               wr_en    = 1'b1;
               ev.done  = 1'b1;
               ev.hits  = modify_ff ? 2'd2 : 2'd1;
               state_in = ST_IDLE;
            end else if (inv_vec != '0) begin
               wr_en    = 1'b1;
               ev.done  = 1'b1;
               ev.miss  = 1'b1;
               ev.hits  = {1'b0, modify_ff};
               state_in = ST_IDLE;
            end else begin
               scan_in       = WCNT_W'(1);
               best_in       = '0;
               best_stamp_in = way_stamp[0];
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one way a cycle; strict less-than keeps the lowest way on ties
            if (CMP_W'(scan_ff) < CMP_W'(cfg.ways_in_use)) begin
               if (scan_stamp < best_stamp_ff) begin
                  best_in       = scan_ff[WAY_W-1:0];
                  best_stamp_in = scan_stamp;
               end
               scan_in = scan_ff + 1'b1;
            end else begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            wr_en    = 1'b1;
            ev.done  = 1'b1;
            ev.miss  = 1'b1;
            ev.evict = 1'b1;
            ev.hits  = {1'b0, modify_ff};
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         time_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         time_ff  <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff        <= set_in;
      tag_ff        <= tag_in;
      modify_ff     <= modify_in;
      scan_ff       <= scan_in;
      best_ff       <= best_in;
      best_stamp_ff <= best_stamp_in;
   end

endmodule

/* hdl/salc_stats.sv */
module salc_stats (
   input  logic                           clock,
   input  logic                           reset,
   input  salc_pkg::salc_event_type       ev,
   output logic                           rsp_strobe,
   output logic [1:0]                     rsp_hits_now,
   output logic                           rsp_missed_now,
   output logic                           rsp_evicted_now,
   output logic [salc_pkg::COUNT_W-1:0]   rsp_total_hits,
   output logic [salc_pkg::COUNT_W-1:0]   rsp_total_misses,
   output logic [salc_pkg::COUNT_W-1:0]   rsp_total_evictions
);
   import salc_pkg::*;

   logic [COUNT_W-1:0] hit_ff, hit_in;
   logic [COUNT_W-1:0] miss_ff, miss_in;
   logic [COUNT_W-1:0] evict_ff, evict_in;
   logic               strobe_ff;
   logic [1:0]         hits_now_ff;
   logic               missed_now_ff;
   logic               evicted_now_ff;
   logic [COUNT_W:0]   hit_sum;
   logic [COUNT_W:0]   miss_sum;
   logic [COUNT_W:0]   evict_sum;

   always_comb begin
      hit_sum   = {1'b0, hit_ff} + (COUNT_W + 1)'(ev.hits);
      miss_sum  = {1'b0, miss_ff} + (COUNT_W + 1)'(ev.miss);
      evict_sum = {1'b0, evict_ff} + (COUNT_W + 1)'(ev.evict);
      hit_in    = hit_sum[COUNT_W] ? '1 : hit_sum[COUNT_W-1:0];
      miss_in   = miss_sum[COUNT_W] ? '1 : miss_sum[COUNT_W-1:0];
      evict_in  = evict_sum[COUNT_W] ? '1 : evict_sum[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff    <= '0;
         miss_ff   <= '0;
         evict_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ev.done;
         if (ev.done) begin
            hit_ff   <= hit_in;
            miss_ff  <= miss_in;
            evict_ff <= evict_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ev.done) begin
         hits_now_ff    <= ev.hits;
         missed_now_ff  <= ev.miss;
         evicted_now_ff <= ev.evict;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_hits_now        = hits_now_ff;
   assign rsp_missed_now      = missed_now_ff;
   assign rsp_evicted_now     = evicted_now_ff;
   assign rsp_total_hits      = hit_ff;
   assign rsp_total_misses    = miss_ff;
   assign rsp_total_evictions = evict_ff;

endmodule

/* hdl/set_assoc_lru_cache_model_top.sv */
// Set-associative LRU cache model. Raise start with an access when busy is low;
// one result comes back on the rsp_ ports, marked by rsp_strobe for a single
// cycle, and must be taken then, since the block cannot be stalled. An
// instruction fetch finishes at once (result the next cycle, next item the
// same cycle). A data access reads the set row from the line memory, checks all
// ways in use at once, and writes the row back, busy through the read and
// lookup states, when it hits or finds a free way. A miss on a full set walks
// the ways one per cycle for the oldest stamp, then writes the row in the evict
// state. A modify costs the same as a load. After reset the line memory is
// cleared one set per cycle, with busy high until all sets are clear;
// configuration writes are taken at any time but belong in idle periods.
module set_assoc_lru_cache_model_top #(
   parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
   parameter int STAMP_WIDTH  = salc_pkg::DEF_STAMP_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_operation,
   input  logic [salc_pkg::ADDR_W-1:0]    req_address,
   output logic                           rsp_strobe,
   output logic [1:0]                     rsp_hits_now,
   output logic                           rsp_missed_now,
   output logic                           rsp_evicted_now,
   output logic [salc_pkg::COUNT_W-1:0]   rsp_total_hits,
   output logic [salc_pkg::COUNT_W-1:0]   rsp_total_misses,
   output logic [salc_pkg::COUNT_W-1:0]   rsp_total_evictions,
   input  logic                           csr_write,
   input  logic [salc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import salc_pkg::*;

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int ROW_W    = MAX_WAYS * (1 + TAG_W + STAMP_WIDTH);

   salc_cfg_type   cfg;
   salc_event_type ev;
   logic             rd_en;
   logic [SET_W-1:0] rd_addr;
   logic [ROW_W-1:0] rd_data;
   logic             wr_en;
   logic [SET_W-1:0] wr_addr;
   logic [ROW_W-1:0] wr_data;

   salc_csr #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   salc_line_mem #(
      .DEPTH  (NUM_SETS),
      .ADDR_B (SET_W),
      .ROW_W  (ROW_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   salc_ctrl #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .STAMP_WIDTH  (STAMP_WIDTH),
      .SET_W        (SET_W),
      .ROW_W        (ROW_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_address   (req_address),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .ev            (ev)
   );

   salc_stats u_stats (
      .clock               (clock),
      .reset               (reset),
      .ev                  (ev),
      .rsp_strobe          (rsp_strobe),
      .rsp_hits_now        (rsp_hits_now),
      .rsp_missed_now      (rsp_missed_now),
      .rsp_evicted_now     (rsp_evicted_now),
      .rsp_total_hits      (rsp_total_hits),
      .rsp_total_misses    (rsp_total_misses),
      .rsp_total_evictions (rsp_total_evictions)
   );

endmodule
